// ----- hw/rtl/dthb_pkg.sv -----
// Package for the date to hours since base block.
// Holds the item types, the register indexes and the calendar constants.
// No dependencies.
package dthb_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } date_t;

    typedef struct packed {
        logic [26:0] elapsed_hours;
        logic        before_base;
    } result_t;

    typedef enum logic [1:0] {
        CFG_BASE_YEAR  = 2'd0,
        CFG_BASE_MONTH = 2'd1,
        CFG_BASE_DAY   = 2'd2,
        CFG_BASE_HOUR  = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned HOURS_W    = 28;
    localparam int unsigned DAYS_W     = 23;
    localparam int unsigned ABS_STAGES = 4;

    localparam logic [13:0] BASE_YEAR_RST  = 14'd2025;
    localparam logic [3:0]  BASE_MONTH_RST = 4'd3;
    localparam logic [4:0]  BASE_DAY_RST   = 5'd14;
    localparam logic [4:0]  BASE_HOUR_RST  = 5'd0;

    // floor(x / 25) equals (x * 5243) >> 17 for every x below 8192.
    localparam logic [12:0] RECIP25       = 13'd5243;
    localparam int unsigned RECIP25_SHIFT = 17;

    localparam logic [26:0] HOURS_MAX = 27'h7FF_FFFF;

    // Days in the months before the given one of a common year; month is 1 to 12.
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ----- hw/rtl/dthb_abs_hours.sv -----
// Four-stage pipe that turns a date and hour into an absolute hour count.
// Each stage loads when its enable bit is high; depends on dthb_pkg.
module dthb_abs_hours import dthb_pkg::*; (
    input  logic                  aclk,
    input  logic [ABS_STAGES-1:0] stage_en,
    input  date_t                 date_in,
    output logic [HOURS_W-1:0]    hours_out
);

    // Stage 1: month clamp, month table and the reciprocal product for year / 100.
    logic [3:0]  month_clamped;
    logic [24:0] prod_next;
    logic [13:0] s1_year_reg;
    logic [11:0] s1_quot4_reg;
    logic [24:0] s1_prod_reg;
    logic [8:0]  s1_dbm_reg;
    logic        s1_late_reg;
    logic [4:0]  s1_day_reg;
    logic [4:0]  s1_hour_reg;

    always_comb begin
        if (date_in.month == 4'd0) begin
            month_clamped = 4'd1;
        end else if (date_in.month > 4'd12) begin
            month_clamped = 4'd12;
        end else begin
            month_clamped = date_in.month;
        end
        prod_next = 25'(date_in.year[13:2]) * 25'(RECIP25);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_year_reg  <= date_in.year;
            s1_quot4_reg <= date_in.year[13:2];
            s1_prod_reg  <= prod_next;
            s1_dbm_reg   <= days_before_month(month_clamped);
            s1_late_reg  <= (month_clamped > 4'd2);
            s1_day_reg   <= date_in.day;
            s1_hour_reg  <= date_in.hour;
        end
    end

    // Stage 2: leap-year test, closed-form leap-day count and 365 days a year.
    logic [7:0]  cent;
    logic [12:0] cent_x25;
    logic        div100;
    logic        leap;
    logic [12:0] ceil4;
    logic [8:0]  ceil100;
    logic [6:0]  ceil400;
    logic [12:0] corr_next;
    logic [22:0] y365_next;
    logic [22:0] s2_y365_reg;
    logic [12:0] s2_corr_reg;
    logic        s2_extra_reg;
    logic [8:0]  s2_dbm_reg;
    logic [4:0]  s2_day_reg;
    logic [4:0]  s2_hour_reg;

    always_comb begin
        cent     = s1_prod_reg[RECIP25_SHIFT+7:RECIP25_SHIFT];
        cent_x25 = 13'(cent) * 13'd25;
        div100   = (s1_year_reg[1:0] == 2'd0) && (cent_x25 == 13'(s1_quot4_reg));
        leap     = (s1_year_reg[1:0] == 2'd0) && (!div100 || (cent[1:0] == 2'd0));
        // Ceilings of year/4, year/100 and year/400 count the multiples below the year.
        ceil4    = 13'(s1_quot4_reg) + 13'(s1_year_reg[1:0] != 2'd0);
        ceil100  = 9'(cent) + 9'(!div100);
        ceil400  = 7'(cent[7:2]) + 7'(!(div100 && (cent[1:0] == 2'd0)));
        corr_next = ceil4 - 13'(ceil100) + 13'(ceil400);
        y365_next = 23'(s1_year_reg) * 23'd365;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s2_y365_reg  <= y365_next;
            s2_corr_reg  <= corr_next;
            s2_extra_reg <= s1_late_reg && leap;
            s2_dbm_reg   <= s1_dbm_reg;
            s2_day_reg   <= s1_day_reg;
            s2_hour_reg  <= s1_hour_reg;
        end
    end

    // Stage 3: day count.
    logic [DAYS_W-1:0] days_next;
    logic [DAYS_W-1:0] s3_days_reg;
    logic [4:0]        s3_hour_reg;

    assign days_next = s2_y365_reg + DAYS_W'(s2_corr_reg) + DAYS_W'(s2_dbm_reg)
                     + DAYS_W'(s2_day_reg) + DAYS_W'(s2_extra_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s3_days_reg <= days_next;
            s3_hour_reg <= s2_hour_reg;
        end
    end

    // Stage 4: hour count.
    logic [HOURS_W-1:0] hours_next;
    logic [HOURS_W-1:0] s4_hours_reg;

    assign hours_next = HOURS_W'(s3_days_reg) * HOURS_W'(24) + HOURS_W'(s3_hour_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s4_hours_reg <= hours_next;
        end
    end

    assign hours_out = s4_hours_reg;

endmodule

// ----- hw/rtl/date_to_hours_since_base.sv -----
// Top level: whole hours from a configurable base instant to each input date.
// Uses dthb_pkg and two dthb_abs_hours pipes, one for items and one for the base.
//
//   port group     dir   handshake            payload
//   s_             in    s_valid / s_ready    date_t   (year, month, day, hour)
//   m_             out   m_valid / m_ready    result_t (elapsed_hours, before_base)
//   cfg_           in    cfg_valid/cfg_ready  cfg_index, cfg_data (base registers)
//
// One item per cycle while the output is not stalled: the accepting edge loads the first
// of four conversion stages, and the compare and subtract register follows the fourth.
// Reset empties the pipe and sets the base to 2025-03-14 hour 0; the base hour
// count settles once a reset or a register write has passed through the base pipe.
// A stall holds each occupied stage; empty stages still fill behind it.
module date_to_hours_since_base import dthb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  date_t                 s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Base registers.
    logic [13:0] base_year_reg;
    logic [3:0]  base_month_reg;
    logic [4:0]  base_day_reg;
    logic [4:0]  base_hour_reg;
    date_t       base_date;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_year_reg  <= BASE_YEAR_RST;
            base_month_reg <= BASE_MONTH_RST;
            base_day_reg   <= BASE_DAY_RST;
            base_hour_reg  <= BASE_HOUR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BASE_YEAR:  base_year_reg  <= cfg_data[13:0];
                CFG_BASE_MONTH: base_month_reg <= cfg_data[3:0];
                CFG_BASE_DAY:   base_day_reg   <= cfg_data[4:0];
                CFG_BASE_HOUR:  base_hour_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign base_date = '{year: base_year_reg, month: base_month_reg,
                         day: base_day_reg, hour: base_hour_reg};

    // Valid bits and per-stage ready for the item pipe.
    logic [ABS_STAGES-1:0] valid_reg;
    logic [ABS_STAGES-1:0] valid_next;
    logic [ABS_STAGES-1:0] stage_ready;
    logic                  out_ready;

    assign out_ready = !m_valid || m_ready;
    assign s_ready   = stage_ready[0];

    always_comb begin
        stage_ready[ABS_STAGES-1] = !valid_reg[ABS_STAGES-1] || out_ready;
        for (int k = ABS_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next[0] = stage_ready[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < ABS_STAGES; k++) begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    logic [HOURS_W-1:0] item_hours;
    logic [HOURS_W-1:0] base_hours;

    dthb_abs_hours u_item_hours (
        .aclk      (aclk),
        .stage_en  (stage_ready),
        .date_in   (s_data),
        .hours_out (item_hours)
    );

    // The base pipe runs freely, so it holds the current base once a change has passed through it.
    dthb_abs_hours u_base_hours (
        .aclk      (aclk),
        .stage_en  ({ABS_STAGES{1'b1}}),
        .date_in   (base_date),
        .hours_out (base_hours)
    );

    // Output stage: difference, sign and saturation.
    logic [HOURS_W-1:0] diff;
    result_t            result_next;
    logic               m_valid_reg;
    result_t            m_data_reg;

    always_comb begin
        diff = item_hours - base_hours;
        if (item_hours < base_hours) begin
            result_next.elapsed_hours = '0;
            result_next.before_base   = 1'b1;
        end else if (diff[HOURS_W-1]) begin
            result_next.elapsed_hours = HOURS_MAX;
            result_next.before_base   = 1'b0;
        end else begin
            result_next.elapsed_hours = diff[HOURS_W-2:0];
            result_next.before_base   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= valid_reg[ABS_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_data_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
